// File: sv/dqvs_pkg.sv
`timescale 1ns / 1ps
// Shared types, command and status codes for the deque with value search.
// No dependencies.
package dqvs_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the item and result transfers
  localparam int CMD_BITS    = 3;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_PEEK       = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_CONTAINS   = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE     = 3'd6;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0]          command;
    logic signed [VALUE_BITS-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]       status;
    logic                         found;
    logic signed [VALUE_BITS-1:0] front_value;
    logic signed [VALUE_BITS-1:0] back_value;
    logic [COUNT_BITS-1:0]        entry_count;
    logic                         is_empty;
  } res_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

// File: sv/dqvs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dqvs_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/deque_with_value_search_top.sv
`timescale 1ns / 1ps
// Bounded deque of signed values with contains and remove-first-match.
// Depends on dqvs_pkg and dqvs_ram.
//
// A bounded double-ended queue held in a ring inside one synchronous RAM
// (one write port, one registered read port). Each input transfer carries
// one command and yields exactly one result transfer with the status, the
// found flag, the front and back values, the count and an empty flag as
// they stand after the command. Items are handled one at a time. Push, peek,
// an unused code and a pop that leaves the store empty or finds it empty
// need no RAM read; any other pop reads the new end entry from the RAM.
// Contains and remove walk the store from the front, one RAM read per
// cycle; a remove then closes the gap by copying each later entry one place
// forward, overlapping those reads with the writes. Front and back values
// are kept in registers, so the result never waits on a second RAM read. The
// result sits in an output register: a new command is taken while the
// previous result still waits to be transferred, and the block only stalls a
// finished result until the output register frees up. The RAM needs no
// clearing after reset; only occupied slots are ever read.
module deque_with_value_search_top #(
  parameter int DEPTH       = dqvs_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dqvs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dqvs_pkg::cmd_item_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dqvs_pkg::res_item_t out_data
);

  import dqvs_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(DEPTH);
  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  // Ring slot of the entry at the given offset from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0]    h,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - AW){1'b0}}, h} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic [CMD_BITS-1:0]     cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0]  val_r, val_nxt;
  logic [VALUE_WIDTH-1:0]  front_r, front_nxt;
  logic [VALUE_WIDTH-1:0]  back_r, back_nxt;
  logic [VALUE_WIDTH-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        ridx_r, ridx_nxt;
  logic                    rv_r, rv_nxt;
  logic [STATUS_BITS-1:0]  status_r, status_nxt;
  logic                    found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_item_t               out_data_r, out_data_nxt;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [VALUE_WIDTH-1:0]  rd_data;

  logic [VALUE_WIDTH+VALUE_BITS-1:0] in_val_wide;
  logic [VALUE_WIDTH-1:0]            in_val;
  logic [VALUE_WIDTH+VALUE_BITS-1:0] front_wide;
  logic [VALUE_WIDTH+VALUE_BITS-1:0] back_wide;
  logic [CNT_W+COUNT_BITS-1:0]       cnt_wide;
  logic [AW-1:0]                     head_dec;
  logic                              in_take;
  logic                              issue;
  logic                              hit;
  logic                              out_free;

  // Sign-extend the input, then keep the stored width
  assign in_val_wide = {{VALUE_WIDTH{in_data.value[VALUE_BITS-1]}}, in_data.value};
  assign in_val      = in_val_wide[VALUE_WIDTH-1:0];
  // Stored bits shown zero-extended or cut to the result width
  assign front_wide  = {{VALUE_BITS{1'b0}}, front_r};
  assign back_wide   = {{VALUE_BITS{1'b0}}, back_r};
  assign cnt_wide    = {{COUNT_BITS{1'b0}}, occ_r};

  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
  assign in_take  = in_valid && !in_stall;
  assign issue    = idx_r < occ_r;
  assign hit      = rv_r && (rd_data == val_r);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dqvs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_data.command)
            CMD_POP_FRONT,
            CMD_POP_BACK: state_nxt = (occ_r > CNT_ONE) ? ST_FETCH : ST_DONE;
            CMD_CONTAINS,
            CMD_REMOVE:   state_nxt = ST_SCAN;
            default:      state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (hit) begin
          state_nxt = (cmd_r == CMD_REMOVE) ? ST_SHIFT : ST_DONE;
        end else if (!rv_r && !issue) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (!rv_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM access and result register
  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    ridx_nxt      = ridx_r;
    rv_nxt        = rv_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd_nxt    = in_data.command;
          val_nxt    = in_val;
          status_nxt = STATUS_OK;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          rv_nxt     = 1'b0;
          unique case (in_data.command)
            CMD_PUSH_FRONT: begin
              if (occ_r == DEPTH_C) begin
                status_nxt = STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = head_dec;
                wr_data   = in_val;
                head_nxt  = head_dec;
                occ_nxt   = occ_r + CNT_ONE;
                front_nxt = in_val;
                if (occ_r == '0) begin
                  back_nxt = in_val;
                end
              end
            end
            CMD_PUSH_BACK: begin
              if (occ_r == DEPTH_C) begin
                status_nxt = STATUS_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = slot_of(head_r, occ_r);
                wr_data  = in_val;
                occ_nxt  = occ_r + CNT_ONE;
                back_nxt = in_val;
                if (occ_r == '0) begin
                  front_nxt = in_val;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (occ_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                head_nxt = slot_of(head_r, CNT_ONE);
                occ_nxt  = occ_r - CNT_ONE;
                rd_en    = occ_r > CNT_ONE;
                rd_addr  = slot_of(head_r, CNT_ONE);
              end
            end
            CMD_POP_BACK: begin
              if (occ_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end else begin
                occ_nxt = occ_r - CNT_ONE;
                rd_en   = occ_r > CNT_ONE;
                rd_addr = slot_of(head_r, occ_r - CNT_TWO);
              end
            end
            CMD_PEEK: begin
              if (occ_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (cmd_r == CMD_POP_FRONT) begin
          front_nxt = rd_data;
        end else begin
          back_nxt = rd_data;
        end
      end

      ST_SCAN: begin
        // One read issued per cycle; the compare works on the registered read data
        rd_en   = issue;
        rd_addr = slot_of(head_r, idx_r);
        rv_nxt  = issue;
        if (issue) begin
          idx_nxt  = idx_r + CNT_ONE;
          ridx_nxt = idx_r;
        end
        if (rv_r) begin
          prev_nxt = rd_data;
        end
        if (hit) begin
          found_nxt = 1'b1;
          // Removing the back entry: the one before it becomes the back
          if (cmd_r == CMD_REMOVE && ridx_r == occ_r - CNT_ONE && ridx_r != '0) begin
            back_nxt = prev_r;
          end
        end
      end

      ST_SHIFT: begin
        // Entry at ridx moves one place towards the front
        rd_en   = issue;
        rd_addr = slot_of(head_r, idx_r);
        rv_nxt  = issue;
        if (issue) begin
          idx_nxt  = idx_r + CNT_ONE;
          ridx_nxt = idx_r;
        end
        if (rv_r) begin
          wr_en   = 1'b1;
          wr_addr = slot_of(head_r, ridx_r - CNT_ONE);
          wr_data = rd_data;
          if (ridx_r == CNT_ONE) begin
            front_nxt = rd_data;
          end
        end else begin
          occ_nxt = occ_r - CNT_ONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.found       = found_r;
          out_data_nxt.entry_count = cnt_wide[COUNT_BITS-1:0];
          out_data_nxt.is_empty    = (occ_r == '0);
          if (occ_r == '0) begin
            out_data_nxt.front_value = '0;
            out_data_nxt.back_value  = '0;
          end else begin
            out_data_nxt.front_value = front_wide[VALUE_BITS-1:0];
            out_data_nxt.back_value  = back_wide[VALUE_BITS-1:0];
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    prev_r     <= prev_nxt;
    idx_r      <= idx_nxt;
    ridx_r     <= ridx_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sv/dqvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the deque result channel, bound to the top level.
// Depends on dqvs_pkg and deque_with_value_search_top.
module dqvs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input dqvs_pkg::res_item_t out_data
);

  import dqvs_pkg::*;

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // An empty store reports a zero count and zero end values
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.entry_count == '0)
    else $error("empty flag with non-zero count");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.front_value == '0 && out_data.back_value == '0)
    else $error("empty store shows end values");

  // A match only ever comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == STATUS_OK)
    else $error("found flag with error status");

endmodule

bind deque_with_value_search_top dqvs_checker u_dqvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for deque_with_value_search_top: directed edge cases, then random
// command streams with idling and back-pressure, checked against a behavioural deque.
// Depends on dqvs_pkg and the block's RTL.
module tb;
  import dqvs_pkg::*;

  localparam int DQ_DEPTH = DEPTH_DEF;
  // Spare code of the 3-bit command field: the block treats it as a no-op
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
  localparam int TIMEOUT_NS  = 1_000_000;
  // Wait after the last result, with a margin to catch strays
  localparam int TAIL_CYCLES = 2 * DQ_DEPTH + 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cmd_item_t in_data;
  logic      out_valid;
  logic      out_stall;
  res_item_t out_data;

  deque_with_value_search_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Behavioural copy of the ring store: head slot wraps naturally at 4 bits
  logic signed [VALUE_BITS-1:0] dq_mem [DQ_DEPTH];
  logic [3:0]                   dq_head;
  int                           dq_count;

  // Results predicted at each input transfer, oldest first
  res_item_t pending_results[$];

  int errors         = 0;
  int checked        = 0;
  int full_drops     = 0;
  int empty_refusals = 0;
  int search_hits    = 0;
  int peak_count     = 0;
  int cmd_seen [8];

  // Pacing knobs shared between the test tasks and the receiver idling process
  bit tx_jitter      = 1'b0;
  bit rx_jitter      = 1'b0;
  int rx_hold_cycles = 0;

  // Values reused often so that contains and remove actually find things
  logic [31:0] value_pool [8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'd42, 32'hFFFF_FFD6, 32'h55AA_55AA};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("deque_with_value_search_top: mismatch");
    $finish;
  end

  // Receiver: random stall bursts, plus the long hold-off when asked
  initial begin : rx_pace
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall = 1'b1;
        rx_hold_cycles--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(1, 16) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    res_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, out_data);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        compare_field("status", exp_r.status, out_data.status);
        compare_field("found", exp_r.found, out_data.found);
        compare_field("front_value", exp_r.front_value, out_data.front_value);
        compare_field("back_value", exp_r.back_value, out_data.back_value);
        compare_field("entry_count", exp_r.entry_count, out_data.entry_count);
        compare_field("is_empty", exp_r.is_empty, out_data.is_empty);
      end
    end
  end

  function automatic logic [3:0] ring_slot(int offset);
    return dq_head + offset[3:0];
  endfunction

  // Applies one command to the behavioural deque and returns what the block should report
  function automatic res_item_t apply_deque_cmd(cmd_item_t item);
    res_item_t r;
    int hit;
    r = '0;
    r.status = STATUS_OK;
    hit = -1;
    case (item.command)
      CMD_PUSH_FRONT: begin
        if (dq_count == DQ_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          dq_head = dq_head - 4'd1;
          dq_mem[dq_head] = item.value;
          dq_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (dq_count == DQ_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          dq_mem[ring_slot(dq_count)] = item.value;
          dq_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          dq_head = dq_head + 4'd1;
          dq_count--;
        end
      end
      CMD_POP_BACK: begin
        if (dq_count == 0) r.status = STATUS_EMPTY;
        else dq_count--;
      end
      CMD_PEEK: begin
        if (dq_count == 0) r.status = STATUS_EMPTY;
      end
      CMD_CONTAINS, CMD_REMOVE: begin
        for (int i = 0; i < dq_count; i++) begin
          if (hit < 0 && dq_mem[ring_slot(i)] == item.value) hit = i;
        end
        r.found = (hit >= 0);
        // remove: first match only, later entries move one place towards the front
        if (item.command == CMD_REMOVE && hit >= 0) begin
          for (int k = hit; k + 1 < dq_count; k++)
            dq_mem[ring_slot(k)] = dq_mem[ring_slot(k + 1)];
          dq_count--;
        end
      end
      default: ;
    endcase
    if (dq_count != 0) begin
      r.front_value = dq_mem[ring_slot(0)];
      r.back_value  = dq_mem[ring_slot(dq_count - 1)];
    end
    r.entry_count = dq_count[COUNT_BITS-1:0];
    r.is_empty    = (dq_count == 0);
    return r;
  endfunction

  function automatic cmd_item_t make_cmd(logic [CMD_BITS-1:0] c, logic [31:0] v);
    cmd_item_t item;
    item.command = c;
    item.value   = v;
    return item;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Mix of commands with the given push and pop percentages; the rest are
  // peeks, searches, removes and the odd unused code
  function automatic cmd_item_t random_cmd(int push_pct, int pop_pct);
    int r;
    logic [CMD_BITS-1:0] c;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else begin
      r = $urandom_range(0, 19);
      if (r < 5) c = CMD_PEEK;
      else if (r < 11) c = CMD_CONTAINS;
      else if (r < 18) c = CMD_REMOVE;
      else c = CMD_UNUSED;
    end
    return make_cmd(c, pick_value());
  endfunction

  // One input transfer; valid is left high afterwards so back-to-back items
  // never see valid dropped and raised in the same step
  task automatic send_cmd(cmd_item_t item);
    res_item_t exp_r;
    int gap;
    gap = (tx_jitter && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_r = apply_deque_cmd(item);
    pending_results.push_back(exp_r);
    cmd_seen[item.command]++;
    if (exp_r.status == STATUS_FULL) full_drops++;
    if (exp_r.status == STATUS_EMPTY) empty_refusals++;
    if (exp_r.found) search_hits++;
    if (dq_count > peak_count) peak_count = dq_count;
  endtask

  // Sender goes quiet until every predicted result has been transferred
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Refusals and no-match searches on an empty store, and the unused code
  task automatic test_empty_store();
    send_cmd(make_cmd(CMD_PEEK, 32'h0));
    send_cmd(make_cmd(CMD_POP_FRONT, 32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_POP_BACK, 32'h0));
    send_cmd(make_cmd(CMD_CONTAINS, 32'h0));
    send_cmd(make_cmd(CMD_REMOVE, 32'h0));
    send_cmd(make_cmd(CMD_UNUSED, 32'hFFFF_FFFF));
  endtask

  // Fill to DEPTH from both ends with extreme values and a repeated value, push
  // into the full store at both ends, remove the front-most copy, then pop back
  task automatic test_fill_and_overflow();
    logic [31:0] fill_vals [16] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                                    32'd5, 32'd5, 32'h1, 32'hFFFF_FFFE,
                                    32'h5555_5555, 32'hAAAA_AAAA, 32'd5, 32'h4000_0000,
                                    32'hBFFF_FFFF, 32'd3, 32'h0F0F_0F0F, 32'hF0F0_F0F0};
    for (int i = 0; i < 16; i++)
      send_cmd(make_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, fill_vals[i]));
    send_cmd(make_cmd(CMD_PUSH_FRONT, 32'd9));
    send_cmd(make_cmd(CMD_PUSH_BACK, 32'd9));
    send_cmd(make_cmd(CMD_REMOVE, 32'd5));
    send_cmd(make_cmd(CMD_POP_BACK, 32'h0));
  endtask

  // Phases of 40 items that grow, shrink or hold the occupancy, each with its
  // own choice of idling on either side
  task automatic test_random_traffic(int n);
    int phase;
    int push_pct;
    int pop_pct;
    phase = 0;
    push_pct = 35;
    pop_pct = 35;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        phase = $urandom_range(0, 2);
        tx_jitter = ($urandom_range(0, 3) != 0);
        rx_jitter = ($urandom_range(0, 3) != 0);
        case (phase)
          0: begin
            push_pct = 75;
            pop_pct = 10;
          end
          1: begin
            push_pct = 10;
            pop_pct = 75;
          end
          default: begin
            push_pct = 35;
            pop_pct = 35;
          end
        endcase
      end
      send_cmd(random_cmd(push_pct, pop_pct));
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills its output register and stalls its input
  task automatic test_output_backpressure(int n);
    wait_for_results();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < n; i++) send_cmd(random_cmd(40, 30));
    wait_for_results();
  endtask

  // Final stretch: full rate on both sides
  task automatic test_streaming_tail(int n);
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    for (int i = 0; i < n; i++) send_cmd(random_cmd(40, 35));
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < DQ_DEPTH; i++) dq_mem[i] = '0;
    dq_head  = '0;
    dq_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_fill_and_overflow();
    test_random_traffic(640);
    test_output_backpressure(40);
    test_streaming_tail(200);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d push front, %0d push back, %0d pop front, %0d pop back, %0d peek,",
             cmd_seen[CMD_PUSH_FRONT], cmd_seen[CMD_PUSH_BACK], cmd_seen[CMD_POP_FRONT],
             cmd_seen[CMD_POP_BACK], cmd_seen[CMD_PEEK]);
    $display("%0d contains, %0d remove, %0d unused; %0d full drops, %0d empty refusals,",
             cmd_seen[CMD_CONTAINS], cmd_seen[CMD_REMOVE], cmd_seen[CMD_UNUSED], full_drops,
             empty_refusals);
    $display("%0d matches, %0d results checked, peak occupancy %0d.",
             search_hits, checked, peak_count);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("deque_with_value_search_top: match");
    end else begin
      $display("deque_with_value_search_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dqvs_pkg.sv
sv/dqvs_ram.sv
sv/deque_with_value_search_top.sv
sv/dqvs_checker.sv
test/tb.sv
